>>> hw/rtl/kcd_pkg.sv
// kcd_pkg: shared types and constants for the key click / double / long detector
// used by every rtl file of the block, depends on nothing

package kcd_pkg;

  localparam int CNT_W  = 16;
  localparam int IDX_W  = 3;
  localparam int DATA_W = 16;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // register indexes on the config port
  localparam logic [IDX_W-1:0] REG_DEBOUNCE      = 3'd0;
  localparam logic [IDX_W-1:0] REG_LONG_PRESS    = 3'd1;
  localparam logic [IDX_W-1:0] REG_MIN_PRESS     = 3'd2;
  localparam logic [IDX_W-1:0] REG_GAP_OPEN      = 3'd3;
  localparam logic [IDX_W-1:0] REG_GAP_CLOSE     = 3'd4;
  localparam logic [IDX_W-1:0] REG_CLICK_TIMEOUT = 3'd5;

  // reset values of the registers
  localparam logic [7:0]  RST_DEBOUNCE      = 8'd5;
  localparam logic [15:0] RST_LONG_PRESS    = 16'd400;
  localparam logic [7:0]  RST_MIN_PRESS     = 8'd5;
  localparam logic [7:0]  RST_GAP_OPEN      = 8'd20;
  localparam logic [7:0]  RST_GAP_CLOSE     = 8'd70;
  localparam logic [7:0]  RST_CLICK_TIMEOUT = 8'd65;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_CLICK  = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } event_t;

  typedef struct packed {
    logic [7:0]  debounce_ticks;
    logic [15:0] long_press_ticks;
    logic [7:0]  min_press_ticks;
    logic [7:0]  gap_open_ticks;
    logic [7:0]  gap_close_ticks;
    logic [7:0]  click_timeout_ticks;
  } cfg_t;

endpackage

>>> hw/rtl/key_click_double_long_detector_core.sv
// key_click_double_long_detector_core: top level of the key event detector
// depends on kcd_pkg, kcd_cfg_regs, kcd_engine, kcd_out_buf
//
// output: an accepted tick's event is registered into the output register, or into the skid entry when that is held
// throughput: one tick per cycle while in_stall is low
// reset: rst (sync, active high) returns to idle, counter 0, thresholds to defaults

module key_click_double_long_detector_core (
  input  logic                       clk,
  input  logic                       rst,
  // tick input channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       key_pressed,
  // event output channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 event_res,
  // config write channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [kcd_pkg::IDX_W-1:0]  cfg_index,
  input  logic [kcd_pkg::DATA_W-1:0] cfg_data
);

  kcd_pkg::cfg_t   cfg;
  kcd_pkg::event_t ev;
  logic            tick_accept;
  logic            buf_full;

  // the skid stage holds one extra event, so the input only stalls when
  // both the output register and the skid entry are occupied
  assign in_stall    = buf_full;
  assign tick_accept = in_valid && !in_stall;

  kcd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // step machine advances once per accepted tick transfer
  kcd_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .tick_accept (tick_accept),
    .key_pressed (key_pressed),
    .cfg         (cfg),
    .ev          (ev)
  );

  // every tick yields exactly one event, none included
  kcd_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (tick_accept),
    .push_ev   (ev),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .event_res (event_res)
  );

endmodule

>>> hw/rtl/kcd_cfg_regs.sv
// kcd_cfg_regs: threshold registers written over the config port
// depends on kcd_pkg

module kcd_cfg_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [kcd_pkg::IDX_W-1:0]  cfg_index,
  input  logic [kcd_pkg::DATA_W-1:0] cfg_data,
  output kcd_pkg::cfg_t              cfg
);

  // writes never wait
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks      <= kcd_pkg::RST_DEBOUNCE;
      cfg.long_press_ticks    <= kcd_pkg::RST_LONG_PRESS;
      cfg.min_press_ticks     <= kcd_pkg::RST_MIN_PRESS;
      cfg.gap_open_ticks      <= kcd_pkg::RST_GAP_OPEN;
      cfg.gap_close_ticks     <= kcd_pkg::RST_GAP_CLOSE;
      cfg.click_timeout_ticks <= kcd_pkg::RST_CLICK_TIMEOUT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        kcd_pkg::REG_DEBOUNCE:      cfg.debounce_ticks      <= cfg_data[7:0];
        kcd_pkg::REG_LONG_PRESS:    cfg.long_press_ticks    <= cfg_data[15:0];
        kcd_pkg::REG_MIN_PRESS:     cfg.min_press_ticks     <= cfg_data[7:0];
        kcd_pkg::REG_GAP_OPEN:      cfg.gap_open_ticks      <= cfg_data[7:0];
        kcd_pkg::REG_GAP_CLOSE:     cfg.gap_close_ticks     <= cfg_data[7:0];
        kcd_pkg::REG_CLICK_TIMEOUT: cfg.click_timeout_ticks <= cfg_data[7:0];
        default: ; // index outside the register list is dropped
      endcase
    end
  end

endmodule

>>> hw/rtl/kcd_engine.sv
// kcd_engine: per-tick step machine and saturating tick counter
// depends on kcd_pkg

module kcd_engine (
  input  logic             clk,
  input  logic             rst,
  input  logic             tick_accept,
  input  logic             key_pressed,
  input  kcd_pkg::cfg_t    cfg,
  output kcd_pkg::event_t  ev
);

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_DEBOUNCE = 3'd1,
    ST_HOLD     = 3'd2,
    ST_CLASSIFY = 3'd3,
    ST_GAP      = 3'd4,
    ST_SECOND   = 3'd5
  } step_t;

  step_t                     step, step_next;
  logic [kcd_pkg::CNT_W-1:0] tick_count, tick_count_next;
  logic [kcd_pkg::CNT_W-1:0] cnt_inc;
  logic                      in_window;

  // saturating increment
  assign cnt_inc = (tick_count == kcd_pkg::CNT_MAX) ? tick_count
                                                    : tick_count + 16'd1;

  assign in_window = (cnt_inc > {8'd0, cfg.gap_open_ticks}) &&
                     (cnt_inc < {8'd0, cfg.gap_close_ticks});

  always_comb begin
    step_next       = step;
    tick_count_next = tick_count;
    ev              = kcd_pkg::EV_NONE;
    unique case (step)
      ST_IDLE: begin
        if (key_pressed) step_next = ST_DEBOUNCE;
      end
      ST_DEBOUNCE: begin
        tick_count_next = cnt_inc;
        if (cnt_inc >= {8'd0, cfg.debounce_ticks}) begin
          tick_count_next = '0;
          step_next       = key_pressed ? ST_HOLD : ST_IDLE;
        end
      end
      ST_HOLD: begin
        if (key_pressed) tick_count_next = cnt_inc;
        else             step_next       = ST_CLASSIFY;
      end
      ST_CLASSIFY: begin
        // long test first, whatever the thresholds
        tick_count_next = '0;
        if (tick_count > cfg.long_press_ticks) begin
          step_next = ST_IDLE;
          ev        = kcd_pkg::EV_LONG;
        end else if (tick_count > {8'd0, cfg.min_press_ticks}) begin
          step_next = ST_GAP;
        end else begin
          step_next = ST_IDLE;
        end
      end
      ST_GAP: begin
        tick_count_next = cnt_inc;
        if (in_window) begin
          if (key_pressed) begin
            step_next       = ST_SECOND;
            tick_count_next = '0;
          end else if (cnt_inc > {8'd0, cfg.click_timeout_ticks}) begin
            step_next       = ST_IDLE;
            tick_count_next = '0;
            ev              = kcd_pkg::EV_CLICK;
          end
        end
      end
      ST_SECOND: begin
        if (key_pressed) begin
          tick_count_next = cnt_inc;
        end else begin
          step_next       = ST_IDLE;
          tick_count_next = '0;
          ev              = kcd_pkg::EV_DOUBLE;
        end
      end
      default: begin
        step_next       = ST_IDLE;
        tick_count_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step       <= ST_IDLE;
      tick_count <= '0;
    end else if (tick_accept) begin
      step       <= step_next;
      tick_count <= tick_count_next;
    end
  end

  a_event_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (tick_accept && ev != kcd_pkg::EV_NONE) |=> (step == ST_IDLE && tick_count == '0))
    else $error("event did not return machine to idle");

  a_long_from_classify: assert property (@(posedge clk) disable iff (rst)
    (tick_accept && ev == kcd_pkg::EV_LONG) |-> (step == ST_CLASSIFY))
    else $error("long press outside classify step");

  a_hold_without_tick: assert property (@(posedge clk) disable iff (rst)
    !tick_accept |=> ($stable(step) && $stable(tick_count)))
    else $error("state moved without a tick");

endmodule

>>> hw/rtl/kcd_out_buf.sv
// kcd_out_buf: output register plus skid stage for the event channel
// depends on kcd_pkg

module kcd_out_buf (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  kcd_pkg::event_t push_ev,
  output logic            full,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [1:0]      event_res
);

  logic            skid_valid;
  kcd_pkg::event_t skid_ev;
  kcd_pkg::event_t out_ev;
  logic            pop;

  assign full      = skid_valid;
  assign pop       = out_valid && !out_stall;
  assign event_res = out_ev;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_ev     <= skid_ev;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
        out_ev    <= push_ev;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_valid <= 1'b1;
        out_ev    <= push_ev;
      end else begin
        skid_valid <= 1'b1;
        skid_ev    <= push_ev;
      end
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with output register empty");

endmodule
